// ===== rtl/core/pkar_pkg.sv =====
// ----------------------------------------------------------------------------
// pkar_pkg: shared definitions for the per-key edge and auto-repeat block
// Key table sizing, field widths, register map and divider handshake types.
// ----------------------------------------------------------------------------
package pkar_pkg;

  // key table sizing
  localparam int KEYS  = 256;
  localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;

  // field widths
  localparam int KEY_W = 8;
  localparam int MS_W  = 16;
  localparam int SUM_W = MS_W + 1;

  // stream payload widths
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  // default repeat interval after reset
  localparam logic [MS_W-1:0] DEFAULT_INTERVAL_MS = MS_W'(1000);

  // input item kinds (tuser)
  localparam logic MODE_SCAN = 1'b0;
  localparam logic MODE_SET  = 1'b1;

  // register map
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_ENABLE = '0;

  // remainder unit request and response
  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [MS_W-1:0]  divisor;
  } rem_req_t;

  typedef struct packed {
    logic            done;
    logic [MS_W-1:0] rem;
  } rem_rsp_t;

endpackage

// ===== rtl/core/pkar_rem.sv =====
// ----------------------------------------------------------------------------
// pkar_rem: iterative remainder unit
// Restoring division, one dividend bit per cycle; returns only the remainder.
// ----------------------------------------------------------------------------
module pkar_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  pkar_pkg::rem_req_t req,
  output pkar_pkg::rem_rsp_t rsp
);

  localparam int CNT_W = $clog2(pkar_pkg::SUM_W + 1);

  logic                      busy_r;
  logic                      done_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [pkar_pkg::SUM_W-1:0] dvd_r;
  logic [pkar_pkg::MS_W-1:0]  dvs_r;
  logic [pkar_pkg::MS_W-1:0]  rem_r;

  logic [pkar_pkg::SUM_W-1:0] trial;
  logic [pkar_pkg::SUM_W-1:0] diff;
  logic                       fits;

  // one trial subtraction per cycle
  assign trial = {rem_r, dvd_r[pkar_pkg::SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(pkar_pkg::SUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[pkar_pkg::SUM_W-2:0], 1'b0};
      rem_r <= fits ? diff[pkar_pkg::MS_W-1:0] : trial[pkar_pkg::MS_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

`ifndef NO_ASSERTIONS
  // result pulse only ends a busy run
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("remainder done without busy");

  // remainder below divisor when reported
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r)) else $error("remainder not below divisor");

  // no restart while busy
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("remainder unit restarted while busy");
`endif

endmodule

// ===== rtl/core/per_key_edge_and_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// per_key_edge_and_auto_repeat: per-key edge detection with typematic repeat
// Keeps per-key level, repeat timer and interval in on-chip memories and
// reports held, press, release and auto-repeat for each scanned key.
//
//   channel | direction | ports        | carries
//   --------+-----------+--------------+-----------------------------------
//   in_     | slave     | tvalid/ready | scan or set-interval item
//   out_    | master    | tvalid/ready | one result per item
//   cfg_    | apb slave | psel..pready | enable register at addresses 0 to 3
//
// A scan item steps through read, read-back, update and load before the next
// transfer; its result is registered at the load step. Set items, disabled
// scans and out-of-range scans go straight to the load step. A timer at or
// past twice the interval first waits for the remainder unit. No clearing pass
// after reset: per-key valid bits stand in. A stalled result waits in the output
// register; the next item runs up to its result and then holds.
// ----------------------------------------------------------------------------
module per_key_edge_and_auto_repeat (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // key_index[7:0], pressed[8], elapsed_ms[24:9], interval_ms[40:25]
  input  logic [pkar_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode
  input  logic                               in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // key_out[7:0], held[8], press_edge[9], release_edge[10], repeat_pulse[11]
  output logic [pkar_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pkar_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int STAT_W = pkar_pkg::MS_W + 1;

  // sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  // input field unpacking
  logic [pkar_pkg::KEY_W-1:0] in_key;
  logic                       in_pressed;
  logic [pkar_pkg::MS_W-1:0]  in_elapsed;
  logic [pkar_pkg::MS_W-1:0]  in_interval;
  logic [pkar_pkg::IDX_W-1:0] in_idx;
  logic                       in_range;
  logic                       in_xfer;

  assign in_key      = in_tdata[7:0];
  assign in_pressed  = in_tdata[8];
  assign in_elapsed  = in_tdata[24:9];
  assign in_interval = in_tdata[40:25];
  assign in_idx      = pkar_pkg::IDX_W'(in_key);
  assign in_range    = 32'(in_key) < pkar_pkg::KEYS;
  assign in_tready   = (state_r == ST_IDLE);
  assign in_xfer     = in_tvalid && in_tready;

  // configuration port
  logic cfg_wr;
  logic cfg_hit;
  logic enable_r;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[pkar_pkg::CFG_ADDR_W-1:2] == pkar_pkg::REG_ENABLE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign cfg_prdata = cfg_hit ? {31'd0, enable_r} : 32'd0;

  // per-key valid bits
  logic [pkar_pkg::KEYS-1:0] seen_r;
  logic [pkar_pkg::KEYS-1:0] ival_ok_r;

  // memories: level and timer, and repeat interval
  logic [STAT_W-1:0]         stat_mem [pkar_pkg::KEYS];
  logic [pkar_pkg::MS_W-1:0] ival_mem [pkar_pkg::KEYS];
  logic [STAT_W-1:0]         stat_q_r;
  logic [pkar_pkg::MS_W-1:0] ival_q_r;
  logic                      stat_we;
  logic [STAT_W-1:0]         stat_wdata;
  logic                      ival_we;
  logic                      scan_rd;

  // held item fields
  logic [pkar_pkg::IDX_W-1:0] idx_r;
  logic                       pressed_r;
  logic [pkar_pkg::MS_W-1:0]  elapsed_r;

  // values after the memory read
  logic                       seen_q_r;
  logic                       prev_q_r;
  logic [pkar_pkg::MS_W-1:0]  timer_q_r;
  logic [pkar_pkg::MS_W-1:0]  iv_r;
  logic [pkar_pkg::SUM_W-1:0] sum_r;

  // result under construction
  logic [pkar_pkg::KEY_W-1:0] res_key_r, res_key_nxt;
  logic [3:0]                 res_flags_r, res_flags_nxt;

  // output register
  logic                            out_valid_r;
  logic [pkar_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                            out_load;

  // remainder unit
  pkar_pkg::rem_req_t rem_req;
  pkar_pkg::rem_rsp_t rem_rsp;

  pkar_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  assign ival_we = in_xfer && (in_tuser == pkar_pkg::MODE_SET) && in_range;
  assign scan_rd = in_xfer && (in_tuser == pkar_pkg::MODE_SCAN) && enable_r && in_range;

  // update decision on the read-back entry
  logic                       cmp_lt_iv;
  logic                       cmp_lt_2iv;
  logic [pkar_pkg::SUM_W-1:0] sum_less_iv;
  logic                       keep_down;

  assign cmp_lt_iv   = sum_r < {1'b0, iv_r};
  assign cmp_lt_2iv  = sum_r < {iv_r, 1'b0};
  assign sum_less_iv = sum_r - {1'b0, iv_r};
  assign keep_down   = pressed_r && prev_q_r;

  always_comb begin
    state_nxt        = state_r;
    res_key_nxt      = res_key_r;
    res_flags_nxt    = res_flags_r;
    stat_we          = 1'b0;
    stat_wdata       = {pressed_r, {pkar_pkg::MS_W{1'b0}}};
    rem_req.start    = 1'b0;
    rem_req.dividend = sum_r;
    rem_req.divisor  = iv_r;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          res_key_nxt   = enable_r ? in_key : '0;
          res_flags_nxt = '0;
          state_nxt     = scan_rd ? ST_READ : ST_DONE;
        end
      end
      ST_READ: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        // flags: {repeat, release, press, held}
        state_nxt = ST_DONE;
        stat_we   = 1'b1;
        if (!seen_q_r) begin
          res_flags_nxt = {3'b000, pressed_r};
        end else begin
          res_flags_nxt = {1'b0, !pressed_r && prev_q_r, pressed_r && !prev_q_r, pressed_r};
          if (keep_down) begin
            if (iv_r == '0) begin
              // zero interval: pulse every held scan, timer untouched
              res_flags_nxt[3] = 1'b1;
              stat_wdata       = {1'b1, timer_q_r};
            end else if (cmp_lt_iv) begin
              stat_wdata = {1'b1, sum_r[pkar_pkg::MS_W-1:0]};
            end else if (cmp_lt_2iv) begin
              res_flags_nxt[3] = 1'b1;
              stat_wdata       = {1'b1, sum_less_iv[pkar_pkg::MS_W-1:0]};
            end else begin
              // timer far past interval: full remainder
              res_flags_nxt[3] = 1'b1;
              stat_we          = 1'b0;
              rem_req.start    = 1'b1;
              state_nxt        = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (rem_rsp.done) begin
          stat_we    = 1'b1;
          stat_wdata = {1'b1, rem_rsp.rem};
          state_nxt  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      seen_r      <= '0;
      ival_ok_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        enable_r <= cfg_pwdata[0];
        seen_r   <= '0;
      end else if (state_r == ST_CALC) begin
        seen_r[idx_r] <= 1'b1;
      end
      if (ival_we) begin
        ival_ok_r[in_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (ival_we) begin
      ival_mem[in_idx] <= in_interval;
    end
    if (scan_rd) begin
      ival_q_r <= ival_mem[in_idx];
      stat_q_r <= stat_mem[in_idx];
    end
    if (stat_we) begin
      stat_mem[idx_r] <= stat_wdata;
    end
  end

  // item and read-back payload
  always_ff @(posedge clk) begin
    res_key_r   <= res_key_nxt;
    res_flags_r <= res_flags_nxt;
    if (in_xfer) begin
      idx_r     <= in_idx;
      pressed_r <= in_pressed;
      elapsed_r <= in_elapsed;
    end
    if (state_r == ST_READ) begin
      seen_q_r  <= seen_r[idx_r];
      prev_q_r  <= stat_q_r[STAT_W-1];
      timer_q_r <= stat_q_r[pkar_pkg::MS_W-1:0];
      iv_r      <= ival_ok_r[idx_r] ? ival_q_r : pkar_pkg::DEFAULT_INTERVAL_MS;
      sum_r     <= {1'b0, stat_q_r[pkar_pkg::MS_W-1:0]} + {1'b0, elapsed_r};
    end
    if (out_load) begin
      out_data_r <= {4'd0, res_flags_r, res_key_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // remainder unit only started from the update step
  a_rem_start: assert property (@(posedge clk) disable iff (!rst_n)
    rem_req.start |-> (state_r == ST_CALC)) else $error("remainder start outside update");

  // remainder answer arrives only while waiting for it
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_rsp.done |-> (state_r == ST_DIV)) else $error("remainder done outside wait");

  // a repeat pulse only on a held key
  a_pulse_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[11]) |-> out_data_r[8]) else $error("repeat without held");

  // press and release never together
  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[9] && out_data_r[10])) else $error("press and release");

  // level memory only written in update or remainder wait
  a_stat_we: assert property (@(posedge clk) disable iff (!rst_n)
    stat_we |-> (state_r == ST_CALC || state_r == ST_DIV)) else $error("stray memory write");
`endif

endmodule
